// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Needs clk and rst_n (active low) in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FFKC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define FFKC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/ffkc_pkg.sv =====
// Package for the four-function key calculator: key codes, operation codes,
// key classes and the command/status structs between controller and datapath.
package ffkc_pkg;

    localparam int KEY_W   = 8;
    localparam int VALUE_W = 16;
    localparam int ITER_N  = VALUE_W;          // one bit per iteration step
    localparam int CNT_W   = $clog2(ITER_N);

    // ASCII key codes
    localparam logic [KEY_W-1:0] KEY_MUL   = 8'h2A;  // '*'
    localparam logic [KEY_W-1:0] KEY_ADD   = 8'h2B;  // '+'
    localparam logic [KEY_W-1:0] KEY_SUB   = 8'h2D;  // '-'
    localparam logic [KEY_W-1:0] KEY_DIV   = 8'h2F;  // '/'
    localparam logic [KEY_W-1:0] KEY_ENTER = 8'h0A;  // newline
    localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h63;  // 'c'
    localparam logic [KEY_W-1:0] KEY_D0    = 8'h30;  // '0'
    localparam logic [KEY_W-1:0] KEY_D9    = 8'h39;  // '9'

    localparam logic [VALUE_W-1:0] ENTRY_LIMIT = 16'd1000;
    localparam logic [VALUE_W-1:0] DIV_FAULT_VALUE = 16'hFFFF;

    // Pending operation
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_MUL  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    // Class of the held key
    typedef enum logic [2:0] {
        KIND_IGNORE = 3'd0,
        KIND_DIGIT  = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_OPER   = 3'd3,
        KIND_ENTER  = 3'd4
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_key;   // capture the input beat
        logic exec;        // single-cycle key handling
        logic iter_start;  // load the shift/add or shift/subtract unit
        logic iter_step;   // one bit of multiply or divide
        logic load_out;    // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  long_op;    // newline needing the iterative unit
        logic  iter_last;  // final iteration step this cycle
        logic  out_free;   // output register can take a result
    } status_t;

endpackage

// ===== design/ffkc_ctrl.sv =====
// Controller for the four-function key calculator: one-hot state machine
// issuing commands to ffkc_dp. Depends on ffkc_pkg.
module ffkc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffkc_pkg::status_t status,
    output ffkc_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_ITER = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_key = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.kind == ffkc_pkg::KIND_IGNORE)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.long_op)
                begin
                    cmd.iter_start = 1'b1;
                    state_next     = ST_ITER;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ffkc_dp.sv =====
// Datapath for the four-function key calculator: key register, entry,
// operand and pending operation, a bit-serial multiply/divide unit and the
// output register. Depends on ffkc_pkg.
module ffkc_dp #(
    parameter int VALUE_W = ffkc_pkg::VALUE_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ffkc_pkg::KEY_W-1:0] key_in,
    input  ffkc_pkg::cmd_t            cmd,
    output ffkc_pkg::status_t         status,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [ffkc_pkg::KEY_W-1:0] echo_char,
    output logic                      show_valid,
    output logic [VALUE_W-1:0]        show_value,
    output logic                      answer_valid,
    output logic                      divide_fault
);

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    logic [ffkc_pkg::KEY_W-1:0] key_reg;
    logic [VALUE_W-1:0]         entry_reg, entry_next;
    logic [VALUE_W-1:0]         operand_reg, operand_next;
    ffkc_pkg::op_t              pending_reg, pending_next;

    // Staged result
    logic               res_show_reg, res_show_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_answer_reg, res_answer_next;
    logic               res_fault_reg, res_fault_next;

    // Iterative unit: acc = product or remainder, wa = multiplier or quotient,
    // wb = multiplicand or divisor
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] wa_reg, wa_next;
    logic [VALUE_W-1:0] wb_reg, wb_next;
    logic [CNT_W-1:0]   cnt_reg;

    // Output register
    logic                       out_valid_reg;
    logic [ffkc_pkg::KEY_W-1:0] out_echo_reg;
    logic                       out_show_reg;
    logic [VALUE_W-1:0]         out_value_reg;
    logic                       out_answer_reg;
    logic                       out_fault_reg;

    ffkc_pkg::kind_t    kind;
    logic               is_mul;
    logic [VALUE_W-1:0] digit_ext;
    logic [VALUE_W-1:0] entry_shifted;
    logic [VALUE_W:0]   rem_shift;
    logic [VALUE_W:0]   rem_diff;
    logic [VALUE_W-1:0] mul_acc;
    logic [VALUE_W-1:0] mul_wb;
    logic [VALUE_W-1:0] mul_wa;

    // Key classification
    always_comb
    begin
        if (key_reg >= ffkc_pkg::KEY_D0 && key_reg <= ffkc_pkg::KEY_D9)
        begin
            kind = ffkc_pkg::KIND_DIGIT;
        end
        else if (key_reg == ffkc_pkg::KEY_CLEAR)
        begin
            kind = ffkc_pkg::KIND_CLEAR;
        end
        else if (key_reg == ffkc_pkg::KEY_MUL || key_reg == ffkc_pkg::KEY_ADD ||
                 key_reg == ffkc_pkg::KEY_SUB || key_reg == ffkc_pkg::KEY_DIV)
        begin
            kind = ffkc_pkg::KIND_OPER;
        end
        else if (key_reg == ffkc_pkg::KEY_ENTER)
        begin
            kind = ffkc_pkg::KIND_ENTER;
        end
        else
        begin
            kind = ffkc_pkg::KIND_IGNORE;
        end
    end

    assign is_mul = (pending_reg == ffkc_pkg::OP_MUL);

    assign status.kind      = kind;
    assign status.long_op   = (kind == ffkc_pkg::KIND_ENTER) &&
                              (is_mul || (pending_reg == ffkc_pkg::OP_DIV &&
                                          entry_reg != '0));
    assign status.iter_last = (cnt_reg == CNT_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Entry times ten plus digit; entry is below the limit here
    assign digit_ext     = {{(VALUE_W-4){1'b0}}, key_reg[3:0]};
    assign entry_shifted = (entry_reg << 3) + (entry_reg << 1) + digit_ext;

    // One multiply step: add then shift
    assign mul_acc = wa_reg[0] ? (acc_reg + wb_reg) : acc_reg;
    assign mul_wb  = wb_reg << 1;
    assign mul_wa  = wa_reg >> 1;

    // One restoring divide step
    assign rem_shift = {acc_reg, wa_reg[VALUE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, wb_reg};

    // Calculator state and iteration next values
    always_comb
    begin
        entry_next      = entry_reg;
        operand_next    = operand_reg;
        pending_next    = pending_reg;
        res_show_next   = res_show_reg;
        res_value_next  = res_value_reg;
        res_answer_next = res_answer_reg;
        res_fault_next  = res_fault_reg;
        acc_next        = acc_reg;
        wa_next         = wa_reg;
        wb_next         = wb_reg;

        if (cmd.exec)
        begin
            res_show_next   = 1'b0;
            res_value_next  = '0;
            res_answer_next = 1'b0;
            res_fault_next  = 1'b0;
            case (kind)
                ffkc_pkg::KIND_DIGIT:
                begin
                    // Full entry: echo only
                    if (entry_reg < ffkc_pkg::ENTRY_LIMIT)
                    begin
                        entry_next     = entry_shifted;
                        res_show_next  = 1'b1;
                        res_value_next = entry_shifted;
                    end
                end
                ffkc_pkg::KIND_CLEAR:
                begin
                    entry_next    = '0;
                    res_show_next = 1'b1;
                end
                ffkc_pkg::KIND_OPER:
                begin
                    case (key_reg)
                        ffkc_pkg::KEY_MUL: pending_next = ffkc_pkg::OP_MUL;
                        ffkc_pkg::KEY_ADD: pending_next = ffkc_pkg::OP_ADD;
                        ffkc_pkg::KEY_SUB: pending_next = ffkc_pkg::OP_SUB;
                        default:           pending_next = ffkc_pkg::OP_DIV;
                    endcase
                    operand_next = entry_reg;
                    entry_next   = '0;
                end
                ffkc_pkg::KIND_ENTER:
                begin
                    case (pending_reg)
                        ffkc_pkg::OP_ADD:
                        begin
                            operand_next    = operand_reg + entry_reg;
                            res_show_next   = 1'b1;
                            res_answer_next = 1'b1;
                            res_value_next  = operand_reg + entry_reg;
                        end
                        ffkc_pkg::OP_SUB:
                        begin
                            operand_next    = operand_reg - entry_reg;
                            res_show_next   = 1'b1;
                            res_answer_next = 1'b1;
                            res_value_next  = operand_reg - entry_reg;
                        end
                        ffkc_pkg::OP_DIV:
                        begin
                            // Only divide by zero reaches here
                            operand_next    = ffkc_pkg::DIV_FAULT_VALUE;
                            res_show_next   = 1'b1;
                            res_answer_next = 1'b1;
                            res_fault_next  = 1'b1;
                            res_value_next  = ffkc_pkg::DIV_FAULT_VALUE;
                        end
                        default:
                        begin
                            // No pending operation: echo only
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.iter_start)
        begin
            acc_next = '0;
            if (is_mul)
            begin
                wa_next = entry_reg;
                wb_next = operand_reg;
            end
            else
            begin
                wa_next = operand_reg;
                wb_next = entry_reg;
            end
        end

        if (cmd.iter_step)
        begin
            if (is_mul)
            begin
                acc_next = mul_acc;
                wa_next  = mul_wa;
                wb_next  = mul_wb;
            end
            else if (!rem_diff[VALUE_W])
            begin
                acc_next = rem_diff[VALUE_W-1:0];
                wa_next  = {wa_reg[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                acc_next = rem_shift[VALUE_W-1:0];
                wa_next  = {wa_reg[VALUE_W-2:0], 1'b0};
            end

            // Final step: store the answer
            if (status.iter_last)
            begin
                operand_next    = is_mul ? acc_next : wa_next;
                res_show_next   = 1'b1;
                res_answer_next = 1'b1;
                res_fault_next  = 1'b0;
                res_value_next  = is_mul ? acc_next : wa_next;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg     <= '0;
            operand_reg   <= '0;
            pending_reg   <= ffkc_pkg::OP_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entry_reg   <= entry_next;
            operand_reg <= operand_next;
            pending_reg <= pending_next;
            if (cmd.iter_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.iter_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_key)
        begin
            key_reg <= key_in;
        end
        res_show_reg   <= res_show_next;
        res_value_reg  <= res_value_next;
        res_answer_reg <= res_answer_next;
        res_fault_reg  <= res_fault_next;
        acc_reg        <= acc_next;
        wa_reg         <= wa_next;
        wb_reg         <= wb_next;
        if (cmd.load_out)
        begin
            out_echo_reg   <= key_reg;
            out_show_reg   <= res_show_reg;
            out_value_reg  <= res_value_reg;
            out_answer_reg <= res_answer_reg;
            out_fault_reg  <= res_fault_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign echo_char    = out_echo_reg;
    assign show_valid   = out_show_reg;
    assign show_value   = out_value_reg;
    assign answer_valid = out_answer_reg;
    assign divide_fault = out_fault_reg;

endmodule

// ===== design/four_function_key_calculator.sv =====
// Top level of the four-function key calculator: joins ffkc_ctrl and ffkc_dp
// to the stream ports. Depends on ffkc_pkg and assert_macros.svh.
//
// channel   direction  beat contents
// s_axis    in         key_char
// m_axis    out        echo_char, show_valid, show_value, answer_valid, divide_fault
//
// A key passes through accept, decode and output load, the load waiting while the
// output register is full; a newline with a pending multiply, or divide by a
// nonzero entry, also runs the 16-step shift/add or divide unit before the load.
// Ignored keys end after decode and give no beat.
// Reset (rst_n low) clears entry, operand, pending operation and output valid.
// While m_tready is low one more non-ignored key is taken; its result waits, s_tready low.
`include "assert_macros.svh"

module four_function_key_calculator #(
    parameter int VALUE_W = ffkc_pkg::VALUE_W
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] echo_char, [8] show_valid, [8+VALUE_W:9] show_value,
    // then answer_valid, divide_fault, zero fill
    output logic [((VALUE_W+11+7)/8)*8-1:0] m_tdata
);

    localparam int PAY_W = VALUE_W + 11;
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;

    ffkc_pkg::cmd_t    cmd;
    ffkc_pkg::status_t status;

    logic [7:0]         echo_char;
    logic               show_valid;
    logic [VALUE_W-1:0] show_value;
    logic               answer_valid;
    logic               divide_fault;

    logic               key_beat;
    logic               fault_beat_ok;
    logic               quiet_beat_ok;

    ffkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffkc_dp #(
        .VALUE_W (VALUE_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_in       (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .echo_char    (echo_char),
        .show_valid   (show_valid),
        .show_value   (show_value),
        .answer_valid (answer_valid),
        .divide_fault (divide_fault)
    );

    // Pack the output beat, lowest field first
    assign m_tdata = {{(TDATA_W-PAY_W){1'b0}}, divide_fault, answer_valid,
                      show_value, show_valid, echo_char};

    // Terms for the checks below
    assign key_beat      = s_tvalid && s_tready;
    assign fault_beat_ok = answer_valid && show_valid &&
                           (show_value == ffkc_pkg::DIV_FAULT_VALUE);
    assign quiet_beat_ok = (show_value == '0) && !answer_valid && !divide_fault;

    // One key in flight: no second accept right after one
    `FFKC_ASSERT(a_one_in_flight, key_beat |=> !s_tready, "key accepted while busy")
    // A held output beat is never overwritten
    `FFKC_NEVER(a_no_overwrite, cmd.load_out && m_tvalid && !m_tready, "output overwritten")
    // A divide fault always comes with an answer of all ones
    `FFKC_ASSERT(a_fault_value, (m_tvalid && divide_fault) |-> fault_beat_ok, "bad fault beat")
    // Without a display update the value and flags are zero
    `FFKC_ASSERT(a_no_show_zero, (m_tvalid && !show_valid) |-> quiet_beat_ok, "stray value")

endmodule
